// ===== rtl/ttpl_pkg.sv =====
// ----------------------------------------------------------------------------
// ttpl_pkg
// Shared types, register indexes and helpers for the track torque power limiter.
// ----------------------------------------------------------------------------
package ttpl_pkg;

	localparam int QW = 16;		// scale fraction bits (Q0.16)

	typedef logic signed [15:0] torque_t;
	typedef logic signed [15:0] speed_t;
	typedef logic signed [23:0] power_t;
	typedef logic signed [31:0] est_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_POWER_BIAS       = 3'd0,
		REG_SQUARE_GAIN      = 3'd1,
		REG_MECH_GAIN        = 3'd2,
		REG_LEFT_TORQUE_MAX  = 3'd3,
		REG_RIGHT_TORQUE_MAX = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [23:0] power_bias;
		logic signed [31:0] square_gain;
		logic signed [23:0] mech_gain;
		logic [14:0]        left_tmax;
		logic [14:0]        right_tmax;
	} cfg_t;

	// entry of the queue between front and back
	typedef struct packed {
		logic    valid;
		logic    scale_req;
		torque_t tl;
		torque_t tr;
		speed_t  vl;
		speed_t  vr;
		power_t  limit;
		est_t    est;
	} qent_t;

	// saturate raw estimate to the 24 bit output range
	function automatic power_t sat24(input est_t x);
		if (x > 32'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (x < -32'sd8388608) begin
			return 24'sh800000;
		end
		return x[23:0];
	endfunction

endpackage

// ===== rtl/ttpl_est.sv =====
// ----------------------------------------------------------------------------
// ttpl_est
// Four-stage power estimator: bias + sq_gain*(tl^2+tr^2) + mech_gain*16*mech.
// ----------------------------------------------------------------------------
module ttpl_est import ttpl_pkg::*; #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  cfg_t          cfg,
	input  logic          in_vld,
	input  torque_t       tl,
	input  torque_t       tr,
	input  speed_t        vl,
	input  speed_t        vr,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output est_t          est,
	output logic [SW-1:0] side_out
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [31:0] sql_s1, sqr_s1, ml_s1, mr_s1;
	logic [31:0] sq_s2, mech_s2;
	logic signed [63:0] psq_s3;
	logic signed [55:0] pm_s3;
	est_t est_s4;
	logic [SW-1:0] side_s1, side_s2, side_s3, side_s4;
	logic [31:0] abs_l, abs_r;
	logic signed [63:0] acc;

	// magnitudes of torque times speed
	assign abs_l = ml_s1[31] ? 32'(-ml_s1) : 32'(ml_s1);
	assign abs_r = mr_s1[31] ? 32'(-mr_s1) : 32'(mr_s1);

	// final sum in units of 2^-32, floored by dropping the low word
	assign acc = {{8{cfg.power_bias[23]}}, cfg.power_bias, 32'b0}
		+ psq_s3
		+ {{4{pm_s3[55]}}, pm_s3, 4'b0};

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			sql_s1  <= 32'(tl * tl);
			sqr_s1  <= 32'(tr * tr);
			ml_s1   <= 32'(tl * vl);
			mr_s1   <= 32'(tr * vr);
			side_s1 <= side_in;
			sq_s2   <= 32'(sql_s1) + 32'(sqr_s1);
			mech_s2 <= abs_l + abs_r;
			side_s2 <= side_s1;
			psq_s3  <= 64'(cfg.square_gain * $signed(sq_s2));
			pm_s3   <= 56'(cfg.mech_gain * $signed(mech_s2));
			side_s3 <= side_s2;
			est_s4  <= acc[63:32];
			side_s4 <= side_s3;
		end
	end

	assign out_vld  = vld_s4;
	assign est      = est_s4;
	assign side_out = side_s4;

endmodule

// ===== rtl/ttpl_fifo.sv =====
// ----------------------------------------------------------------------------
// ttpl_fifo
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module ttpl_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/ttpl_front.sv =====
// ----------------------------------------------------------------------------
// ttpl_front
// Takes input transactions, clamps torques, estimates power, flags scaling.
// ----------------------------------------------------------------------------
module ttpl_front import ttpl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    request_valid,
	input  torque_t left_request,
	input  torque_t right_request,
	input  speed_t  left_speed,
	input  speed_t  right_speed,
	input  power_t  power_limit,
	output logic    q_push,
	output qent_t   q_data,
	input  logic    q_full
);

	typedef struct packed {
		logic    valid;
		power_t  limit;
		torque_t tl;
		torque_t tr;
		speed_t  vl;
		speed_t  vr;
	} fside_t;

	logic en;
	logic vld_s1;
	fside_t side_s1, side_e;
	logic est_vld;
	est_t est_e;
	logic ok;

	// clamp magnitude of t to m
	function automatic torque_t clamp_t(input torque_t t, input logic [14:0] m);
		logic signed [16:0] tt;
		logic signed [16:0] mm;
		tt = {t[15], t};
		mm = {2'b0, m};
		if (tt > mm) begin
			return {1'b0, m};
		end else if (tt < -mm) begin
			return 16'(-$signed({1'b0, m}));
		end
		return t;
	endfunction

	// whole front holds only when its last stage cannot enter the queue
	assign en       = !(est_vld && q_full);
	assign in_stall = !en;
	assign ok       = request_valid && (power_limit > 24'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	// clamp stage; zero torque for a dead budget or an invalid request
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.valid <= request_valid;
			side_s1.limit <= power_limit;
			side_s1.tl    <= ok ? clamp_t(left_request, cfg.left_tmax) : '0;
			side_s1.tr    <= ok ? clamp_t(right_request, cfg.right_tmax) : '0;
			side_s1.vl    <= left_speed;
			side_s1.vr    <= right_speed;
		end
	end

	ttpl_est #(.SW($bits(fside_t))) u_est (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg),
		.in_vld   (vld_s1),
		.tl       (side_s1.tl),
		.tr       (side_s1.tr),
		.vl       (side_s1.vl),
		.vr       (side_s1.vr),
		.side_in  (side_s1),
		.out_vld  (est_vld),
		.est      (est_e),
		.side_out (side_e)
	);

	// classify: scaling needed when positive estimate exceeds a positive budget
	assign q_push           = est_vld && !q_full;
	assign q_data.valid     = side_e.valid;
	assign q_data.scale_req = (side_e.limit > 24'sd0) && (est_e > 32'(side_e.limit))
		&& (est_e > 32'sd0);
	assign q_data.tl        = side_e.tl;
	assign q_data.tr        = side_e.tr;
	assign q_data.vl        = side_e.vl;
	assign q_data.vr        = side_e.vr;
	assign q_data.limit     = side_e.limit;
	assign q_data.est       = est_e;

endmodule

// ===== rtl/ttpl_div.sv =====
// ----------------------------------------------------------------------------
// ttpl_div
// Pipelined restoring divider, one quotient bit per stage: num*2^QW / den.
// ----------------------------------------------------------------------------
module ttpl_div import ttpl_pkg::*; #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [22:0]   num,
	input  logic [31:0]   den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [QW+1];
	logic [31:0]   rem_s  [QW+1];
	logic [31:0]   den_s  [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = {9'b0, num};
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [33:0] diff;

		// trial subtract of the divisor from the doubled remainder
		assign diff = {1'b0, rem_s[i], 1'b0} - {2'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= diff[33] ? {rem_s[i][30:0], 1'b0} : diff[31:0];
				quo_s[i+1]  <= {quo_s[i][QW-2:0], !diff[33]};
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = quo_s[QW];
	assign side_out = side_s[QW];

endmodule

// ===== rtl/ttpl_back.sv =====
// ----------------------------------------------------------------------------
// ttpl_back
// Pops queued items, scales torques when over budget, re-estimates, outputs.
// ----------------------------------------------------------------------------
module ttpl_back import ttpl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  qent_t   q_data,
	input  logic    q_empty,
	output logic    q_pop,
	output logic    out_valid,
	input  logic    out_stall,
	output logic    torque_valid,
	output torque_t left_cmd,
	output torque_t right_cmd,
	output power_t  power_estimate
);

	typedef struct packed {
		logic    valid;
		logic    scale_req;
		torque_t tl;
		torque_t tr;
		speed_t  vl;
		speed_t  vr;
	} dside_t;

	typedef struct packed {
		logic    valid;
		torque_t tl;
		torque_t tr;
	} eside_t;

	logic en;
	logic vld_s1, vld_d, vld_s2, vld_e;
	qent_t ent_s1;
	dside_t dside_in, dside_d;
	logic [QW-1:0] quo_d;
	torque_t tl_s2, tr_s2;
	speed_t vl_s2, vr_s2;
	logic rv_s2;
	eside_t eside_in, side_e;
	est_t est_e;
	logic out_valid_q, tv_q;
	torque_t lt_q, rt_q;
	power_t pw_q;

	// truncate |t|*q/2^QW toward zero, keep sign
	function automatic torque_t scale_t(input torque_t t, input logic [QW-1:0] q);
		logic [15:0] m;
		logic [31:0] p;
		m = t[15] ? 16'(-t) : 16'(t);
		p = 32'(m) * 32'(q);
		return t[15] ? 16'(-$signed(p[31:16])) : $signed(p[31:16]);
	endfunction

	// whole back advances whenever the output register can move
	assign en    = !out_valid_q || !out_stall;
	assign q_pop = !q_empty && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= q_pop;
			vld_s2      <= vld_d;
			out_valid_q <= vld_e;
		end
	end

	// queue read register
	always_ff @(posedge clk) begin
		if (en) begin
			ent_s1 <= q_data;
		end
	end

	assign dside_in.valid     = ent_s1.valid;
	assign dside_in.scale_req = ent_s1.scale_req;
	assign dside_in.tl        = ent_s1.tl;
	assign dside_in.tr        = ent_s1.tr;
	assign dside_in.vl        = ent_s1.vl;
	assign dside_in.vr        = ent_s1.vr;

	// scale = limit*2^16 / estimate
	ttpl_div #(.SW($bits(dside_t))) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.num      (ent_s1.limit[22:0]),
		.den      (ent_s1.est),
		.side_in  (dside_in),
		.out_vld  (vld_d),
		.quo      (quo_d),
		.side_out (dside_d)
	);

	// torque scaling stage
	always_ff @(posedge clk) begin
		if (en) begin
			tl_s2 <= dside_d.scale_req ? scale_t(dside_d.tl, quo_d) : dside_d.tl;
			tr_s2 <= dside_d.scale_req ? scale_t(dside_d.tr, quo_d) : dside_d.tr;
			vl_s2 <= dside_d.vl;
			vr_s2 <= dside_d.vr;
			rv_s2 <= dside_d.valid;
		end
	end

	assign eside_in.valid = rv_s2;
	assign eside_in.tl    = tl_s2;
	assign eside_in.tr    = tr_s2;

	ttpl_est #(.SW($bits(eside_t))) u_est (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg),
		.in_vld   (vld_s2),
		.tl       (tl_s2),
		.tr       (tr_s2),
		.vl       (vl_s2),
		.vr       (vr_s2),
		.side_in  (eside_in),
		.out_vld  (vld_e),
		.est      (est_e),
		.side_out (side_e)
	);

	// output register; invalid requests come out all zero
	always_ff @(posedge clk) begin
		if (en) begin
			tv_q <= side_e.valid;
			lt_q <= side_e.valid ? side_e.tl : '0;
			rt_q <= side_e.valid ? side_e.tr : '0;
			pw_q <= side_e.valid ? sat24(est_e) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign torque_valid   = tv_q;
	assign left_cmd       = lt_q;
	assign right_cmd      = rt_q;
	assign power_estimate = pw_q;

endmodule

// ===== rtl/track_torque_power_limiter_core.sv =====
// ----------------------------------------------------------------------------
// track_torque_power_limiter_core
// Two-track torque clamp and power limiter with a configurable power model.
// ----------------------------------------------------------------------------
// One torque pair is taken per clock and one result leaves per clock when no
// stall holds the flow. The front clamps the torques and runs a four-stage
// power estimator (one clamp stage plus four), then writes a small queue; the
// back reads the queue, runs a 16-stage divider for the limit/estimate
// fraction, scales the torques, runs the estimator again and registers the
// result (one read stage, sixteen, one, four and one). Output stall holds the
// back; the front keeps taking transactions until the queue fills.
module track_torque_power_limiter_core import ttpl_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        write_en,
	input  logic [2:0]  write_index,
	input  logic [31:0] write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        request_valid,
	input  torque_t     left_request,
	input  torque_t     right_request,
	input  speed_t      left_speed,
	input  speed_t      right_speed,
	input  power_t      power_limit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        torque_valid,
	output torque_t     left_cmd,
	output torque_t     right_cmd,
	output power_t      power_estimate
);

	cfg_t cfg_q;
	logic q_push, q_pop, q_full, q_empty;
	qent_t q_wdata, q_rdata;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_bias  <= '0;
			cfg_q.square_gain <= '0;
			cfg_q.mech_gain   <= 24'sd65536;
			cfg_q.left_tmax   <= 15'd32767;
			cfg_q.right_tmax  <= 15'd32767;
		end else if (write_en) begin
			unique case (reg_idx_t'(write_index))
				REG_POWER_BIAS:       cfg_q.power_bias  <= write_data[23:0];
				REG_SQUARE_GAIN:      cfg_q.square_gain <= write_data;
				REG_MECH_GAIN:        cfg_q.mech_gain   <= write_data[23:0];
				REG_LEFT_TORQUE_MAX:  cfg_q.left_tmax   <= write_data[14:0];
				REG_RIGHT_TORQUE_MAX: cfg_q.right_tmax  <= write_data[14:0];
				default: ;
			endcase
		end
	end

	ttpl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.request_valid (request_valid),
		.left_request  (left_request),
		.right_request (right_request),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.power_limit   (power_limit),
		.q_push        (q_push),
		.q_data        (q_wdata),
		.q_full        (q_full)
	);

	ttpl_fifo #(.W($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	ttpl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_data         (q_rdata),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.torque_valid   (torque_valid),
		.left_cmd       (left_cmd),
		.right_cmd      (right_cmd),
		.power_estimate (power_estimate)
	);

	// front only stalls on a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled with room in the queue");

	// invalid request yields an all-zero transaction
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !torque_valid) |->
		(left_cmd == '0 && right_cmd == '0 && power_estimate == '0))
		else $error("invalid request produced nonzero output");

	// left output torque stays within its clamp
	a_left_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && torque_valid) |->
		($signed({left_cmd[15], left_cmd}) <= $signed({2'b0, cfg_q.left_tmax})
		&& $signed({left_cmd[15], left_cmd}) >= -$signed({2'b0, cfg_q.left_tmax})))
		else $error("left torque beyond its clamp");

endmodule

// ===== tb/track_torque_power_limiter_core_tb.sv =====
// ----------------------------------------------------------------------------
// track_torque_power_limiter_core_tb
// Drives torque/speed/budget transactions through the limiter under bursty
// input and random output stall, predicts each result with a behavioral
// power model, and checks every field in order.
// ----------------------------------------------------------------------------
module track_torque_power_limiter_core_tb import ttpl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit       tv;
		torque_t  lt;
		torque_t  rt;
		power_t   pe;
	} torque_result_t;

	int errors = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// expected-result store plus the limiter's own power model
	class limiter_scoreboard;
		longint bias = 0, sq_gain = 0, mech_gain = 65536;
		longint lmax = 32767, rmax = 32767;
		torque_result_t pending[$];

		function void set_reg(input logic [2:0] idx, input logic [31:0] d);
			case (idx)
				REG_POWER_BIAS:       bias = longint'($signed(d[23:0]));
				REG_SQUARE_GAIN:      sq_gain = longint'($signed(d));
				REG_MECH_GAIN:        mech_gain = longint'($signed(d[23:0]));
				REG_LEFT_TORQUE_MAX:  lmax = d[14:0];
				REG_RIGHT_TORQUE_MAX: rmax = d[14:0];
				default: ;
			endcase
		endfunction

		function longint power_of(input longint tl, tr, vl, vr);
			longint a, b, acc;
			a = tl * vl;
			b = tr * vr;
			if (a < 0) a = -a;
			if (b < 0) b = -b;
			acc = (bias <<< 32) + sq_gain * (tl * tl + tr * tr) + mech_gain * 16 * (a + b);
			return acc >>> 32;
		endfunction

		function longint sat(input longint x);
			if (x > 8388607) return 8388607;
			if (x < -8388608) return -8388608;
			return x;
		endfunction

		function longint shrink(input longint t, input longint s);
			longint m;
			m = ((t < 0 ? -t : t) * s) >>> 16;
			return t < 0 ? -m : m;
		endfunction

		function void note_request(input bit rv, input longint lr, rr, vl, vr, lim);
			torque_result_t r;
			longint tl, tr, est, s;
			r = '{0, 0, 0, 0};
			if (rv) begin
				r.tv = 1;
				if (lim <= 0) begin
					r.pe = power_t'(sat(power_of(0, 0, vl, vr)));
				end else begin
					tl = lr > lmax ? lmax : (lr < -lmax ? -lmax : lr);
					tr = rr > rmax ? rmax : (rr < -rmax ? -rmax : rr);
					est = power_of(tl, tr, vl, vr);
					if (est > lim && est > 0) begin
						s = (lim * 65536) / est;
						tl = shrink(tl, s);
						tr = shrink(tr, s);
						est = power_of(tl, tr, vl, vr);
					end
					r.lt = torque_t'(tl);
					r.rt = torque_t'(tr);
					r.pe = power_t'(sat(est));
				end
			end
			pending.push_back(r);
		endfunction

		task check_result(input bit tv, input torque_t lt, rt, input power_t pe);
			torque_result_t e;
			if (pending.size() == 0) begin
				report("unexpected transaction", 0, 0);
			end else begin
				e = pending.pop_front();
				if (tv != e.tv) report("torque_valid", tv, e.tv);
				if (lt != e.lt) report("left_cmd", lt, e.lt);
				if (rt != e.rt) report("right_cmd", rt, e.rt);
				if (pe != e.pe) report("power_estimate", pe, e.pe);
			end
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic write_en = 0;
	logic [2:0] write_index = '0;
	logic [31:0] write_data = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic request_valid = 0;
	torque_t left_request = '0, right_request = '0, left_cmd, right_cmd;
	speed_t left_speed = '0, right_speed = '0;
	power_t power_limit = '0, power_estimate;
	logic torque_valid;

	limiter_scoreboard sb = new();
	int idle_cycles = 0;
	bit stall_quiet = 0;

	track_torque_power_limiter_core dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// output side: random stall pattern with quiet stretches, result checking
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(torque_valid, left_cmd, right_cmd, power_estimate);
		out_stall <= stall_quiet ? 1'b0 : ($urandom_range(0, 3) == 0);
	end

	// watchdog on cycles with no accepted transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
		write_en <= 1;
		write_index <= idx;
		write_data <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
		write_en <= 0;
	endtask

	// wait for the block to drain, then past its latency
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send(input bit rv, input torque_t lr, rr, input speed_t vl, vr,
			input power_t lim);
		in_valid <= 1;
		request_valid <= rv;
		left_request <= lr;
		right_request <= rr;
		left_speed <= vl;
		right_speed <= vr;
		power_limit <= lim;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(rv, lr, rr, vl, vr, lim);
	endtask

	task automatic pause_sender();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic power_t rand_limit();
		case ($urandom_range(0, 5))
			0: return power_t'($urandom);
			1: return power_t'($urandom_range(0, 2000)) - 24'sd500;
			2: return 24'sh7FFFFF;
			default: return power_t'($urandom_range(1, 200000));
		endcase
	endfunction

	task automatic random_phase(input int n);
		int burst;
		burst = 0;
		stall_quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				pause_sender();
				burst = $urandom_range(1, 20);
			end
			burst--;
			send($urandom_range(0, 9) != 0, torque_t'($urandom), torque_t'($urandom),
				speed_t'($urandom), speed_t'($urandom), rand_limit());
		end
		in_valid <= 0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, invalid request, budget at and below zero
		send(0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 24'sd1000);
		send(1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 24'sh7FFFFF);
		send(1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 24'sd1);
		send(1, 16'sd100, -16'sd100, 16'sd50, -16'sd50, 24'sd0);
		send(1, 16'sd100, -16'sd100, 16'sd50, -16'sd50, 24'sh800000);
		send(1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd1);
		send(1, -16'sd1, 16'sd1, 16'sh8000, 16'sh8000, 24'sd5);
		send(1, 16'sd2048, 16'sd2048, 16'sd640, 16'sd640, 24'sd100);
		send(0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd0);
		in_valid <= 0;
		// hold off until everything is out
		drain();

		// square-law model, left torque clamp at zero
		write_reg(REG_POWER_BIAS, 32'd160);
		write_reg(REG_SQUARE_GAIN, 32'd65536);
		write_reg(REG_MECH_GAIN, 32'd0);
		write_reg(REG_LEFT_TORQUE_MAX, 32'd0);
		write_reg(REG_RIGHT_TORQUE_MAX, 32'd20000);
		send(1, 16'sh7FFF, 16'sh8000, 16'sd10, 16'sd10, 24'sd1000);
		send(1, 16'sd300, 16'sd300, 16'sd10, 16'sd10, 24'sd0);
		random_phase(150);
		drain();

		// extreme register values
		write_reg(REG_POWER_BIAS, 32'h00800000);
		write_reg(REG_SQUARE_GAIN, 32'h7FFFFFFF);
		write_reg(REG_MECH_GAIN, 32'h007FFFFF);
		write_reg(REG_LEFT_TORQUE_MAX, 32'h7FFF);
		write_reg(REG_RIGHT_TORQUE_MAX, 32'd0);
		random_phase(200);
		drain();

		write_reg(REG_POWER_BIAS, 32'h007FFFFF);
		write_reg(REG_SQUARE_GAIN, 32'h80000000);
		write_reg(REG_MECH_GAIN, 32'h00800000);
		random_phase(200);
		drain();

		// realistic positive model
		write_reg(REG_POWER_BIAS, 32'd32);
		write_reg(REG_SQUARE_GAIN, 32'd40000);
		write_reg(REG_MECH_GAIN, 32'd65536);
		write_reg(REG_LEFT_TORQUE_MAX, 32'd16384);
		write_reg(REG_RIGHT_TORQUE_MAX, 32'd12000);
		random_phase(400);
		drain();

		for (int k = 0; k < 5; k++) begin
			write_reg(reg_idx_t'(k), $urandom);
			write_reg(reg_idx_t'(k), $urandom);
		end
		random_phase(300);
		drain();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
